@@ rtl/i2c_byte_level_master_top_macros.svh @@
// ----------------------------------------------------------------------------
// I2C byte-level master assertion macros
// Shared property forms for the checker of the byte-level master.
// ----------------------------------------------------------------------------
`ifndef I2C_BYTE_LEVEL_MASTER_TOP_MACROS_SVH
`define I2C_BYTE_LEVEL_MASTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2c master check failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2c master check failed");

`endif

@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master package
// Command codes, bus timing constants and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam logic [2:0] OP_NONE      = 3'd0;
	localparam logic [2:0] OP_START     = 3'd1;
	localparam logic [2:0] OP_STOP      = 3'd2;
	localparam logic [2:0] OP_WRITE     = 3'd3;
	localparam logic [2:0] OP_READ_ACK  = 3'd4;
	localparam logic [2:0] OP_READ_NACK = 3'd5;

	localparam logic [15:0] PHASE_TICKS_RST = 16'd250;

	localparam logic [4:0] START_PHASES = 5'd3;
	localparam logic [4:0] STOP_PHASES  = 5'd2;
	localparam logic [4:0] WRITE_PHASES = 5'd27;
	localparam logic [4:0] READ_PHASES  = 5'd19;

	typedef struct packed {
		logic       nack;
		logic [7:0] rdata;
		logic       done_res;
		logic       busy_res;
		logic       sda;
		logic       scl;
	} res_t;

	function automatic logic [4:0] phase_total(input logic [2:0] op);
		logic [4:0] total;
		case (op)
			OP_START: total = START_PHASES;
			OP_STOP:  total = STOP_PHASES;
			OP_WRITE: total = WRITE_PHASES;
			default:  total = READ_PHASES;
		endcase
		return total;
	endfunction

endpackage

@@ rtl/i2c_byte_level_master_top.sv @@
// ----------------------------------------------------------------------------
// I2C byte-level master
// Tick-driven I2C master that runs start, stop, write and read commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         one bus tick: command, write byte, sampled SDA
// m_axis    out        one result per tick: line drives, status, read byte
// apb       in/out     phase length register at byte address 0
//
// Each request passes an input register and a result register, and a new
// request is taken every cycle while the output is not stalled.
// The sequencer state in the core sets the pace; it advances once per request.
// A stalled output holds its result and stops the input after one more request.
// Reset releases both lines and sets the phase length to 250 ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_byte_level_master_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // op[2:0], wdata[10:3], sda_in[11], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // scl, sda, busy_res, done_res, rdata[11:4], nack[12]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import i2cm_pkg::*;

	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [7:0]  wdata_s1;
	logic        sda_in_s1;
	logic        valid_s2;
	res_t        res_s2;
	res_t        res_next;
	logic        adv;
	logic [15:0] phase_ticks;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (!valid_s2 || m_tready) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= s_tdata[2:0];
			wdata_s1  <= s_tdata[10:3];
			sda_in_s1 <= s_tdata[11];
		end
		if (adv) res_s2 <= res_next;
	end

	i2cm_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.phase_ticks (phase_ticks)
	);

	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.op          (op_s1),
		.wdata       (wdata_s1),
		.sda_in      (sda_in_s1),
		.phase_ticks (phase_ticks),
		.res         (res_next)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'd0, res_s2.nack, res_s2.rdata, res_s2.done_res,
		res_s2.busy_res, res_s2.sda, res_s2.scl};

endmodule

@@ rtl/i2cm_regs.sv @@
// ----------------------------------------------------------------------------
// I2C master register file
// Holds the phase length register behind the configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] phase_ticks
);
	import i2cm_pkg::*;

	logic [15:0] phase_ticks_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && !paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (wr_en) begin
			phase_ticks_q <= pwdata[15:0];
		end
	end

	assign prdata      = paddr[2] ? 32'd0 : {16'd0, phase_ticks_q};
	assign phase_ticks = phase_ticks_q;

endmodule

@@ rtl/i2cm_core.sv @@
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Holds the command state and computes the result of one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [2:0]        op,
	input  logic [7:0]        wdata,
	input  logic              sda_in,
	input  logic [15:0]       phase_ticks,
	output i2cm_pkg::res_t    res
);
	import i2cm_pkg::*;

	logic [15:0] tick_q, tick_d;
	logic [4:0]  phase_q, phase_d;
	logic [1:0]  third_q, third_d;
	logic [7:0]  shift_q, shift_d;
	logic [2:0]  op_q, op_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        ack_q, ack_d;
	logic [7:0]  rx_q, rx_d;

	logic        take;
	logic [2:0]  cur_op;
	logic [4:0]  pi;
	logic [15:0] tc;
	logic [1:0]  kk;
	logic [15:0] tick_inc;
	logic [15:0] limit;
	logic [4:0]  phase_nx;
	logic        done;

	always_comb begin
		take   = (op_q == OP_NONE) && (op >= OP_START) && (op <= OP_READ_NACK);
		cur_op = take ? op : op_q;
		pi     = take ? 5'd0 : phase_q;
		tc     = take ? 16'd0 : tick_q;
		kk     = take ? 2'd0 : third_q;
		shift_d = take ? ((op == OP_WRITE) ? wdata : 8'd0) : shift_q;
		op_d    = cur_op;
		phase_d = pi;
		tick_d  = tc;
		third_d = kk;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		rx_d    = rx_q;
		done    = 1'b0;
		tick_inc = tc + 16'd1;
		limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
		phase_nx = pi + 5'd1;

		if (cur_op != OP_NONE) begin
			if (tc == 16'd0) begin
				case (cur_op)
					OP_START: begin
						scl_d = (pi < 5'd2);
						sda_d = (pi == 5'd0);
					end
					OP_STOP: begin
						scl_d = 1'b1;
						sda_d = (pi != 5'd0);
					end
					OP_WRITE: begin
						if (pi < 5'd24) begin
							if (kk == 2'd0) begin
								scl_d = 1'b0;
								sda_d = shift_d[7];
							end else if (kk == 2'd1) begin
								scl_d = 1'b1;
							end else begin
								scl_d = 1'b0;
								if (pi == 5'd23) sda_d = 1'b1;
							end
						end else if (pi == 5'd24) begin
							scl_d = 1'b0;
							sda_d = 1'b1;
						end else begin
							scl_d = (pi == 5'd25);
						end
					end
					default: begin
						if (pi < 5'd16) begin
							if (!pi[0]) begin
								scl_d = 1'b1;
								sda_d = 1'b1;
							end else begin
								scl_d = 1'b0;
							end
						end else if (pi == 5'd16) begin
							scl_d = 1'b0;
							sda_d = (cur_op == OP_READ_NACK);
						end else begin
							scl_d = (pi == 5'd17);
						end
					end
				endcase
			end

			tick_d = tick_inc;
			if (tick_inc >= limit || tick_inc == 16'd0) begin
				if (cur_op == OP_WRITE) begin
					if (pi < 5'd24 && kk == 2'd2) begin
						shift_d = {shift_d[6:0], 1'b0};
					end else if (pi == 5'd25) begin
						ack_d = sda_in;
					end
				end else if (cur_op == OP_READ_ACK || cur_op == OP_READ_NACK) begin
					if (pi < 5'd16 && !pi[0]) begin
						shift_d = {shift_d[6:0], sda_in};
					end
				end
				tick_d  = 16'd0;
				phase_d = phase_nx;
				third_d = (kk == 2'd2) ? 2'd0 : kk + 2'd1;
				if (phase_nx >= phase_total(cur_op)) begin
					done = 1'b1;
					if (cur_op == OP_READ_ACK || cur_op == OP_READ_NACK) rx_d = shift_d;
					if (cur_op == OP_READ_ACK) sda_d = 1'b1;
					op_d    = OP_NONE;
					phase_d = 5'd0;
					third_d = 2'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			phase_q <= '0;
			third_q <= '0;
			shift_q <= '0;
			op_q    <= OP_NONE;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			rx_q    <= '0;
		end else if (step) begin
			tick_q  <= tick_d;
			phase_q <= phase_d;
			third_q <= third_d;
			shift_q <= shift_d;
			op_q    <= op_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ack_q   <= ack_d;
			rx_q    <= rx_d;
		end
	end

	assign res.scl      = scl_d;
	assign res.sda      = sda_d;
	assign res.busy_res = (op_d != OP_NONE);
	assign res.done_res = done;
	assign res.rdata    = rx_d;
	assign res.nack     = ack_d;

endmodule

@@ rtl/i2cm_checker.sv @@
// ----------------------------------------------------------------------------
// I2C master port checker
// Watches the top-level ports for flow control and status consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "i2c_byte_level_master_top_macros.svh"

module i2cm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	`I2CM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`I2CM_ASSERT_SAME(a_in_stall, !s_tready, m_tvalid && !m_tready)
	`I2CM_ASSERT_SAME(a_done_idle, m_tvalid && m_tdata[3], !m_tdata[2])

endmodule

bind i2c_byte_level_master_top i2cm_checker u_checker (.*);
